### src/grid_edge_edge_neighbor_macros.svh
// ----------------------------------------------------------------------------
// Grid edge neighbor - assertion macros
// Short forms for the concurrent checks of the neighbor lookup block.
// All checks sample on clk and are off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef GRID_EDGE_EDGE_NEIGHBOR_MACROS_SVH
`define GRID_EDGE_EDGE_NEIGHBOR_MACROS_SVH

// Condition holds at every clock edge
`define GEEN_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define GEEN_ASSERT_IMPL(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define GEEN_ASSERT_NEXT(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) else $error(msg);

`endif

### src/geen_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geen_pkg
// Shared widths, register indexes, neighbor position codes and the
// sideband record that rides along the divider pipeline.
// ----------------------------------------------------------------------------
package geen_pkg;

	// Field widths
	localparam int REG_W     = 13;
	localparam int EDGE_W    = 25;
	localparam int POS_W     = 3;
	localparam int CFG_IDX_W = 1;

	// Default lattice limits
	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;

	// Largest dimension a register can express
	localparam int REG_MAX = (2 ** REG_W) - 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

	// Neighbor position codes
	localparam logic [POS_W-1:0] NBR_P1 = 3'd1;
	localparam logic [POS_W-1:0] NBR_P2 = 3'd2;
	localparam logic [POS_W-1:0] NBR_P3 = 3'd3;
	localparam logic [POS_W-1:0] NBR_P4 = 3'd4;
	localparam logic [POS_W-1:0] NBR_P5 = 3'd5;
	localparam logic [POS_W-1:0] NBR_P6 = 3'd6;

	// Query context carried beside the division
	typedef struct packed {
		logic [EDGE_W-1:0] edge_idx;
		logic [POS_W-1:0]  pos;
		logic              vert;
		logic              in_range;
	} geen_side_t;

endpackage

### src/grid_edge_edge_neighbor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_edge_edge_neighbor
// Neighbor edge lookup on a 4-connected pixel lattice.
// ----------------------------------------------------------------------------
// Takes one query per cycle while req_stall is low and returns one result
// per query, in order. A restoring divider splits the edge index into
// column and row, one quotient bit per pipeline stage. Each stage moves
// into a free slot on its own, so a result stalled at the output does not
// block intake while earlier stages have room. A width or height write is
// in effect for the query taken on the following cycle; derived sizes are
// updated in the write cycle.
// ----------------------------------------------------------------------------
`include "grid_edge_edge_neighbor_macros.svh"

module grid_edge_edge_neighbor #(
	parameter int MAX_WIDTH  = geen_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = geen_pkg::DEF_MAX_HEIGHT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_wr_en,
	input  logic [geen_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [geen_pkg::REG_W-1:0]    cfg_data,
	// query channel
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [geen_pkg::EDGE_W-1:0]   edge_index,
	input  logic [geen_pkg::POS_W-1:0]    position,
	// result channel
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [geen_pkg::EDGE_W-1:0]   neighbour_index,
	output logic                          exists
);

	localparam int EW    = geen_pkg::EDGE_W;
	localparam int PSW   = geen_pkg::POS_W;
	localparam int W_CAP = (MAX_WIDTH < geen_pkg::REG_MAX) ? MAX_WIDTH : geen_pkg::REG_MAX;
	localparam int H_CAP = (MAX_HEIGHT < geen_pkg::REG_MAX) ? MAX_HEIGHT : geen_pkg::REG_MAX;
	localparam int WW    = $clog2(W_CAP + 1);
	localparam int HW    = $clog2(H_CAP + 1);
	localparam int QW    = $clog2(H_CAP);
	localparam int PW    = WW + HW;
	localparam int TW    = PW + 1;
	localparam int CT    = (TW > EW) ? TW : EW;
	localparam int MW    = QW + WW;

	// ------------------------------------------------------------------
	// Configuration: clamped dimensions and derived edge counts
	// ------------------------------------------------------------------
	logic [WW-1:0] w_q;
	logic [HW-1:0] h_q;
	logic [PW-1:0] nv_q;
	logic [TW-1:0] tot_q;

	logic          wr_w, wr_h;
	logic [WW-1:0] cw;
	logic [HW-1:0] ch;
	logic [WW-1:0] mul_a;
	logic [HW-1:0] mul_b;
	logic [PW-1:0] prod;

	assign wr_w = cfg_wr_en && (cfg_index == geen_pkg::REG_GRID_WIDTH);
	assign wr_h = cfg_wr_en && (cfg_index == geen_pkg::REG_GRID_HEIGHT);

	// clamp write data into [2, cap]
	always_comb begin
		if (cfg_data < geen_pkg::REG_W'(2)) begin
			cw = WW'(2);
		end else if (32'(cfg_data) > W_CAP) begin
			cw = WW'(W_CAP);
		end else begin
			cw = cfg_data[WW-1:0];
		end
		if (cfg_data < geen_pkg::REG_W'(2)) begin
			ch = HW'(2);
		end else if (32'(cfg_data) > H_CAP) begin
			ch = HW'(H_CAP);
		end else begin
			ch = cfg_data[HW-1:0];
		end
	end

	// one product w*h gives both vertical count and total
	assign mul_a = wr_w ? cw : w_q;
	assign mul_b = wr_h ? ch : h_q;
	assign prod  = PW'(mul_a) * PW'(mul_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q   <= WW'(2);
			h_q   <= HW'(2);
			nv_q  <= PW'(2);
			tot_q <= TW'(4);
		end else if (wr_w || wr_h) begin
			w_q   <= mul_a;
			h_q   <= mul_b;
			nv_q  <= prod - PW'(mul_a);
			tot_q <= {prod, 1'b0} - TW'(mul_a) - TW'(mul_b);
		end
	end

	// ------------------------------------------------------------------
	// Stage load enables
	// ------------------------------------------------------------------
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic ld_s1, ld_s2, ld_s3, ld_s4;
	logic div_up_ld, div_dn_valid;

	assign ld_s4 = !vld_s4 || !rsp_stall;
	assign ld_s3 = !vld_s3 || ld_s4;
	assign ld_s2 = !vld_s2 || div_up_ld;
	assign ld_s1 = !vld_s1 || ld_s2;

	assign req_stall = !ld_s1;

	// ------------------------------------------------------------------
	// s1: capture query
	// ------------------------------------------------------------------
	logic [EW-1:0]  edge_s1;
	logic [PSW-1:0] pos_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ld_s1) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			edge_s1 <= edge_index;
			pos_s1  <= position;
		end
	end

	// ------------------------------------------------------------------
	// s2: classify edge, form dividend and divisor
	// ------------------------------------------------------------------
	logic                 is_vert, in_rng;
	logic [CT-1:0]        hoff;
	logic [EW-1:0]        num_s2;
	logic [WW-1:0]        dvs_s2;
	geen_pkg::geen_side_t side_s2;

	assign is_vert = CT'(edge_s1) < CT'(nv_q);
	assign in_rng  = CT'(edge_s1) < CT'(tot_q);
	assign hoff    = CT'(edge_s1) - CT'(nv_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (ld_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			num_s2           <= is_vert ? edge_s1 : hoff[EW-1:0];
			dvs_s2           <= is_vert ? w_q : w_q - WW'(1);
			side_s2.edge_idx <= edge_s1;
			side_s2.pos      <= pos_s1;
			side_s2.vert     <= is_vert;
			side_s2.in_range <= in_rng;
		end
	end

	// ------------------------------------------------------------------
	// Divider: column/row split
	// ------------------------------------------------------------------
	logic [QW-1:0]        dq;
	logic [WW-1:0]        dr;
	geen_pkg::geen_side_t dside;

	geen_div #(
		.WW (WW),
		.QW (QW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (vld_s2),
		.up_ld    (div_up_ld),
		.up_num   (num_s2),
		.up_dvs   (dvs_s2),
		.up_side  (side_s2),
		.dn_valid (div_dn_valid),
		.dn_ld    (ld_s3),
		.dn_quot  (dq),
		.dn_rem   (dr),
		.dn_side  (dside)
	);

	// ------------------------------------------------------------------
	// s3: row product, boundary check and addend per position
	// ------------------------------------------------------------------
	logic [WW-1:0] mb;
	logic [MW-1:0] mprod;
	logic [EW-1:0] wE, hE, xE, qE, nvE;
	logic          ok, use_m;
	logic [EW-1:0] add;

	logic [EW-1:0] m_s3, edge_s3, add_s3;
	logic          ok_s3, use_m_s3;

	assign mb    = dside.vert ? w_q - WW'(1) : w_q;
	assign mprod = MW'(dq) * MW'(mb);

	assign wE  = EW'(w_q);
	assign hE  = EW'(h_q);
	assign xE  = EW'(dr);
	assign qE  = EW'(dq);
	assign nvE = nv_q[EW-1:0];

	always_comb begin
		ok    = 1'b0;
		use_m = 1'b0;
		add   = '0;
		if (dside.vert) begin
			// vertical edge at column x, row y
			case (dside.pos)
				geen_pkg::NBR_P1: begin
					ok  = qE != '0;
					add = EW'(0) - wE;
				end
				geen_pkg::NBR_P2: begin
					ok    = xE != '0;
					use_m = 1'b1;
					add   = nvE + xE - EW'(1);
				end
				geen_pkg::NBR_P3: begin
					ok    = xE != '0;
					use_m = 1'b1;
					add   = nvE + wE + xE - EW'(2);
				end
				geen_pkg::NBR_P4: begin
					ok  = (qE + EW'(2)) < hE;
					add = wE;
				end
				geen_pkg::NBR_P5: begin
					ok    = xE != (wE - EW'(1));
					use_m = 1'b1;
					add   = nvE + wE + xE - EW'(1);
				end
				geen_pkg::NBR_P6: begin
					ok    = xE != (wE - EW'(1));
					use_m = 1'b1;
					add   = nvE + xE;
				end
				default: begin
					ok = 1'b0;
				end
			endcase
		end else begin
			// horizontal edge at column c, row r
			case (dside.pos)
				geen_pkg::NBR_P1: begin
					ok    = qE != '0;
					use_m = 1'b1;
					add   = xE + EW'(1) - wE;
				end
				geen_pkg::NBR_P2: begin
					ok    = qE != '0;
					use_m = 1'b1;
					add   = xE - wE;
				end
				geen_pkg::NBR_P3: begin
					ok  = xE != '0;
					add = '1;
				end
				geen_pkg::NBR_P4: begin
					ok    = (qE + EW'(1)) < hE;
					use_m = 1'b1;
					add   = xE;
				end
				geen_pkg::NBR_P5: begin
					ok    = (qE + EW'(1)) < hE;
					use_m = 1'b1;
					add   = xE + EW'(1);
				end
				geen_pkg::NBR_P6: begin
					ok  = (xE + EW'(2)) != wE;
					add = EW'(1);
				end
				default: begin
					ok = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (ld_s3) begin
			vld_s3 <= div_dn_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s3) begin
			m_s3     <= EW'(mprod);
			edge_s3  <= dside.edge_idx;
			add_s3   <= add;
			ok_s3    <= ok && dside.in_range;
			use_m_s3 <= use_m;
		end
	end

	// ------------------------------------------------------------------
	// s4: final add, output register
	// ------------------------------------------------------------------
	logic [EW-1:0] sum;
	logic [EW-1:0] nbr_s4;
	logic          ex_s4;

	assign sum = (use_m_s3 ? m_s3 : edge_s3) + add_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (ld_s4) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s4) begin
			nbr_s4 <= ok_s3 ? sum : '0;
			ex_s4  <= ok_s3;
		end
	end

	assign rsp_valid       = vld_s4;
	assign neighbour_index = nbr_s4;
	assign exists          = ex_s4;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`GEEN_ASSERT_ALWAYS(a_dims_clamped, (w_q >= WW'(2)) && (32'(w_q) <= W_CAP) && (h_q >= HW'(2)) && (32'(h_q) <= H_CAP), "lattice dimension outside clamp range")
	`GEEN_ASSERT_ALWAYS(a_nv_below_total, TW'(nv_q) < tot_q, "vertical edge count not below total")
	`GEEN_ASSERT_IMPL(a_none_is_zero, rsp_valid && !exists, neighbour_index == '0, "missing neighbor with nonzero index")
	`GEEN_ASSERT_IMPL(a_stall_only_full, req_stall, vld_s1 && vld_s2, "intake stalled with a free front stage")

endmodule

### src/geen_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geen_div
// Pipelined restoring divider: one quotient bit per stage, QW stages.
// Each stage holds its own valid bit and moves when the next one frees up.
// ----------------------------------------------------------------------------
module geen_div #(
	parameter int WW = 12,
	parameter int QW = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// upstream side
	input  logic                       up_valid,
	output logic                       up_ld,
	input  logic [geen_pkg::EDGE_W-1:0] up_num,
	input  logic [WW-1:0]              up_dvs,
	input  geen_pkg::geen_side_t       up_side,
	// downstream side
	output logic                       dn_valid,
	input  logic                       dn_ld,
	output logic [QW-1:0]              dn_quot,
	output logic [WW-1:0]              dn_rem,
	output geen_pkg::geen_side_t       dn_side
);

	localparam int EW = geen_pkg::EDGE_W;
	localparam int CW = (EW > WW + QW) ? EW : WW + QW;

	logic                 vld_s  [QW];
	logic [EW-1:0]        rem_s  [QW];
	logic [WW-1:0]        dvs_s  [QW];
	logic [QW-1:0]        quo_s  [QW];
	geen_pkg::geen_side_t side_s [QW];
	wire  [QW-1:0]        ld_v;

	assign up_ld = ld_v[0];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int SH = QW - 1 - k;

		logic                 vin;
		logic [EW-1:0]        rin;
		logic [WW-1:0]        din;
		logic [QW-1:0]        qin;
		geen_pkg::geen_side_t sin;
		logic [CW-1:0]        dsh;
		logic [CW-1:0]        diff;
		logic                 geq;

		// stage input select
		if (k == 0) begin : g_first
			assign vin = up_valid;
			assign rin = up_num;
			assign din = up_dvs;
			assign qin = '0;
			assign sin = up_side;
		end else begin : g_next
			assign vin = vld_s[k-1];
			assign rin = rem_s[k-1];
			assign din = dvs_s[k-1];
			assign qin = quo_s[k-1];
			assign sin = side_s[k-1];
		end

		// load enable: empty, or the next stage takes our content
		if (k == QW - 1) begin : g_last
			assign ld_v[k] = !vld_s[k] || dn_ld;
		end else begin : g_mid
			assign ld_v[k] = !vld_s[k] || ld_v[k+1];
		end

		// trial subtract of the shifted divisor
		assign dsh  = CW'(din) << SH;
		assign geq  = CW'(rin) >= dsh;
		assign diff = CW'(rin) - dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (ld_v[k]) begin
				vld_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (ld_v[k]) begin
				rem_s[k]  <= geq ? diff[EW-1:0] : rin;
				dvs_s[k]  <= din;
				quo_s[k]  <= qin | (QW'(geq) << SH);
				side_s[k] <= sin;
			end
		end
	end

	assign dn_valid = vld_s[QW-1];
	assign dn_quot  = quo_s[QW-1];
	assign dn_rem   = rem_s[QW-1][WW-1:0];
	assign dn_side  = side_s[QW-1];

endmodule

### bench/geen_lookup_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geen_lookup_checker
// Watches the query and result channels of the edge neighbor lookup and
// mirrors the width and height writes. For every query transfer it predicts
// the neighbor edge and its inside-image flag, and compares each result
// transfer against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module geen_lookup_checker
	import geen_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data,
	input  logic                 req_valid,
	input  logic                 req_stall,
	input  logic [EDGE_W-1:0]    edge_index,
	input  logic [POS_W-1:0]     position,
	input  logic                 rsp_valid,
	input  logic                 rsp_stall,
	input  logic [EDGE_W-1:0]    neighbour_index,
	input  logic                 exists,
	output int                   mismatches,
	output int                   outstanding
);

	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [EDGE_W-1:0] nbr;
		logic              found;
	} nbr_result_t;

	nbr_result_t      pending_nbrs[$];
	nbr_result_t      head;
	logic [REG_W-1:0] width_reg;
	logic [REG_W-1:0] height_reg;
	int               results_seen;

	// Neighbor edge of edge e at position p for raw register values wr, hr
	function automatic nbr_result_t predict_neighbour(
		input logic [EDGE_W-1:0] e,
		input logic [POS_W-1:0]  p,
		input logic [REG_W-1:0]  wr,
		input logic [REG_W-1:0]  hr
	);
		longint unsigned w, h, nv, total, x, y, c, r, hb, val;
		logic            found;
		nbr_result_t     res;
		// registers below 2 read as 2, above the limit saturate
		w = (wr < 2) ? 2 : ((wr > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : wr);
		h = (hr < 2) ? 2 : ((hr > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : hr);
		nv = w * (h - 1);
		total = nv + (w - 1) * h;
		found = 1'b0;
		val = 0;
		res = '0;
		if (e < total && e < nv) begin
			// vertical edge at (x, y)
			x = e % w;
			y = e / w;
			hb = nv + y * (w - 1);
			case (p)
				NBR_P1: begin found = (y != 0);         val = e - w; end
				NBR_P2: begin found = (x != 0);         val = hb + x - 1; end
				NBR_P3: begin found = (x != 0);         val = hb + (w - 1) + x - 1; end
				NBR_P4: begin found = (y + 2 < h);      val = e + w; end
				NBR_P5: begin found = (x != w - 1);     val = hb + (w - 1) + x; end
				NBR_P6: begin found = (x != w - 1);     val = hb + x; end
				default: found = 1'b0;
			endcase
		end else if (e < total) begin
			// horizontal edge at (c, r)
			c = (e - nv) % (w - 1);
			r = (e - nv) / (w - 1);
			case (p)
				NBR_P1: begin found = (r != 0);         val = (r - 1) * w + c + 1; end
				NBR_P2: begin found = (r != 0);         val = (r - 1) * w + c; end
				NBR_P3: begin found = (c != 0);         val = e - 1; end
				NBR_P4: begin found = (r + 1 < h);      val = r * w + c; end
				NBR_P5: begin found = (r + 1 < h);      val = r * w + c + 1; end
				NBR_P6: begin found = (c + 2 != w);     val = e + 1; end
				default: found = 1'b0;
			endcase
		end
		if (found) begin
			res.nbr   = val[EDGE_W-1:0];
			res.found = 1'b1;
		end
		return res;
	endfunction

	// Register mirror
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg  <= 13'd2;
			height_reg <= 13'd2;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_GRID_WIDTH:  width_reg  <= cfg_data;
				REG_GRID_HEIGHT: height_reg <= cfg_data;
				default: ;
			endcase
		end
	end

	// Predict on query transfers, compare on result transfers
	always @(posedge clk) begin
		if (!arst_n) begin
			pending_nbrs.delete();
			results_seen = 0;
			outstanding <= 0;
		end else begin
			if (req_valid && !req_stall)
				pending_nbrs.push_back(predict_neighbour(edge_index, position,
					width_reg, height_reg));
			if (rsp_valid && !rsp_stall) begin
				if (pending_nbrs.size() == 0) begin
					if (mismatches < MAX_REPORTS)
						$display("[%0t] result %0d with no query waiting: index %h exists %b",
							$realtime, results_seen, neighbour_index, exists);
					mismatches <= mismatches + 1;
				end else begin
					head = pending_nbrs.pop_front();
					if (head.nbr !== neighbour_index || head.found !== exists) begin
						if (mismatches < MAX_REPORTS)
							$display("[%0t] result %0d: index exp %h got %h, exists exp %b got %b",
								$realtime, results_seen, head.nbr, neighbour_index,
								head.found, exists);
						mismatches <= mismatches + 1;
					end
				end
				results_seen++;
			end
			outstanding <= pending_nbrs.size();
		end
	end

endmodule

### bench/tb_grid_edge_edge_neighbor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_edge_edge_neighbor
// Drives neighbor queries into the lookup block over a series of lattice
// sizes (reset size, extremes, out-of-range register values, random sizes)
// with random gaps and output stalls, one long output hold-off and drains
// between sizes. The checker beside the block does the comparing; this top
// makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_grid_edge_edge_neighbor;

	import geen_pkg::*;

	localparam int          IDLE_PCT       = 31;
	localparam int          LATENCY        = 16;
	localparam int          HOLD_CYCLES    = 80;
	localparam int          WATCHDOG_LIMIT = 4000;
	localparam int          PHASE_ITEMS    = 65;
	localparam int          N_FIXED        = 10;
	localparam int          HOLD_PHASE     = 5;
	localparam logic [POS_W-1:0] POS_NONE_LO = 3'd0;
	localparam logic [POS_W-1:0] POS_NONE_HI = 3'd7;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_GRID_WIDTH;
	logic [REG_W-1:0]     cfg_data = '0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	logic [EDGE_W-1:0]    edge_index = '0;
	logic [POS_W-1:0]     position = POS_NONE_LO;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	logic [EDGE_W-1:0]    neighbour_index;
	logic                 exists;

	int          mismatches;
	int          outstanding;
	bit          steady = 1'b0;
	int unsigned hold_reqs = 0;
	int unsigned hold_seen = 0;
	int          hold_left = 0;
	int          quiet_cycles = 0;
	logic [REG_W-1:0] cur_w = 13'd2;
	logic [REG_W-1:0] cur_h = 13'd2;

	// Lattice sizes: extremes, clamped values and a few ordinary ones
	logic [REG_W-1:0] fixed_w [N_FIXED] = '{4096, 2, 0, 8191, 3, 13, 4097, 2, 1, 100};
	logic [REG_W-1:0] fixed_h [N_FIXED] = '{4096, 2, 1, 8191, 5, 7, 2, 4096, 8191, 37};

	// Directed corner queries on the 5 x 4 lattice
	logic [EDGE_W-1:0] corner_edge [8] = '{0, 0, 14, 14, 30, 30, 31, 25'h1FFFFFF};
	logic [POS_W-1:0]  corner_pos  [8] = '{NBR_P1, NBR_P2, NBR_P4, NBR_P5,
		NBR_P6, NBR_P4, NBR_P1, NBR_P3};

	grid_edge_edge_neighbor uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.edge_index      (edge_index),
		.position        (position),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.neighbour_index (neighbour_index),
		.exists          (exists)
	);

	geen_lookup_checker lookup_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.edge_index      (edge_index),
		.position        (position),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.neighbour_index (neighbour_index),
		.exists          (exists),
		.mismatches      (mismatches),
		.outstanding     (outstanding)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Result side: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || cfg_wr_en || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("** grid_edge_edge_neighbor: FAILED **");
			$finish;
		end
	end

	function automatic int unsigned eff_dim(input logic [REG_W-1:0] raw,
		input int unsigned limit);
		if (raw < 2)
			return 2;
		if (raw > limit)
			return limit;
		return raw;
	endfunction

	// One query transfer; returns at the accepting edge
	task automatic send_query(input logic [EDGE_W-1:0] e, input logic [POS_W-1:0] p);
		if (!steady)
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
		req_valid  <= 1'b1;
		edge_index <= e;
		position   <= p;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	// Stop offering and wait for every outstanding result
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_dims(input logic [REG_W-1:0] w, input logic [REG_W-1:0] h);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_GRID_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= REG_GRID_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_w = w;
		cur_h = h;
	endtask

	// Random queries for the current size: lattice borders, range seams, out-of-range edges, unused positions
	task automatic run_random(input int n);
		longint unsigned w, h, nv, total, x, y, val;
		logic [POS_W-1:0] p;
		w = eff_dim(cur_w, DEF_MAX_WIDTH);
		h = eff_dim(cur_h, DEF_MAX_HEIGHT);
		nv = w * (h - 1);
		total = nv + (w - 1) * h;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				4, 5: begin
					// vertical edge, often on a border column or row
					x = $urandom_range(0, w - 1);
					y = $urandom_range(0, h - 2);
					case ($urandom_range(0, 3))
						0: x = 0;
						1: x = w - 1;
						default: ;
					endcase
					case ($urandom_range(0, 3))
						0: y = 0;
						1: y = h - 2;
						default: ;
					endcase
					val = y * w + x;
				end
				6, 7: begin
					// horizontal edge, often on a border column or row
					x = $urandom_range(0, w - 2);
					y = $urandom_range(0, h - 1);
					case ($urandom_range(0, 3))
						0: x = 0;
						1: x = w - 2;
						default: ;
					endcase
					case ($urandom_range(0, 3))
						0: y = 0;
						1: y = h - 1;
						default: ;
					endcase
					val = nv + y * (w - 1) + x;
				end
				8: val = $urandom_range(32'h1FFFFFF, total);
				9: begin
					// seams between the vertical and horizontal ranges
					case ($urandom_range(0, 4))
						0: val = 0;
						1: val = nv - 1;
						2: val = nv;
						3: val = total - 1;
						default: val = total;
					endcase
				end
				default: val = $urandom_range(total - 1, 0);
			endcase
			if ($urandom_range(0, 9) == 0)
				p = $urandom_range(0, 1) ? POS_NONE_HI : POS_NONE_LO;
			else
				p = POS_W'($urandom_range(NBR_P1, NBR_P6));
			send_query(val[EDGE_W-1:0], p);
		end
	endtask

	// Stimulus and verdict
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// size after reset
		run_random(PHASE_ITEMS);
		wait_drained();

		// directed: every position around an inner vertical and horizontal edge,
		// then border, out-of-range and all-ones queries
		write_dims(13'd5, 13'd4);
		for (int p = 0; p < 8; p++) begin
			send_query(25'd7, p[POS_W-1:0]);
			send_query(25'd20, p[POS_W-1:0]);
		end
		for (int i = 0; i < 8; i++)
			send_query(corner_edge[i], corner_pos[i]);
		run_random(40);
		wait_drained();

		for (int i = 0; i < N_FIXED; i++) begin
			if (i == HOLD_PHASE)
				steady <= 1'b1;
			write_dims(fixed_w[i], fixed_h[i]);
			if (i == HOLD_PHASE) begin
				// back-to-back traffic with the output held off to fill the pipe
				run_random(30);
				hold_reqs <= hold_reqs + 1;
				run_random(60);
			end else begin
				run_random(PHASE_ITEMS);
			end
			wait_drained();
			steady <= 1'b0;
		end

		// random sizes, the last from the full register range
		for (int i = 0; i < 3; i++) begin
			if (i == 2)
				write_dims(REG_W'($urandom_range(0, 8191)), REG_W'($urandom_range(0, 8191)));
			else
				write_dims(REG_W'($urandom_range(2, 40)), REG_W'($urandom_range(2, 40)));
			run_random(PHASE_ITEMS);
			wait_drained();
		end

		repeat (2 * LATENCY) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("** grid_edge_edge_neighbor: PASSED **");
		else
			$display("** grid_edge_edge_neighbor: FAILED **");
		$finish;
	end

endmodule
